>>> rtl/amd_pkg.sv
// ----------------------------------------------------------------------------
// amd_pkg: shared types and constants of the affine matrix decomposer
// Holds the stage item layout, the quaternion branch codes, the stage map of
// the pipeline and the digit steps of its square roots.
// ----------------------------------------------------------------------------
package amd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  // Stage map of the pipeline. Stage 0 holds the captured input.
  localparam int LEN_STEPS  = WORD_BITS;      // root bits of a column length
  localparam int NORM_STEPS = FRAC_BITS;      // fraction bits of a normalized entry
  localparam int ROOT_STEPS = FRAC_BITS + 2;  // root bits of the radicand root
  localparam int DIV_STEPS  = FRAC_BITS + 1;  // quotient bits of a side component

  localparam int ST_SQ    = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_LEN0  = 3;
  localparam int ST_NINIT = ST_LEN0 + LEN_STEPS;
  localparam int ST_NDIV0 = ST_NINIT + 1;
  localparam int ST_SIGN  = ST_NDIV0 + NORM_STEPS;
  localparam int ST_BR    = ST_SIGN + 1;
  localparam int ST_ROOT0 = ST_BR + 1;
  localparam int ST_SINIT = ST_ROOT0 + ROOT_STEPS;
  localparam int ST_SDIV0 = ST_SINIT + 1;
  localparam int ST_OUT   = ST_SDIV0 + DIV_STEPS;
  localparam int NSTAGE   = ST_OUT + 1;

  localparam logic [16:0] ONE_Q = 17'h10000;
  localparam logic [17:0] QUAT_ONE = 18'h10000;

  // Which quaternion component comes from the square root.
  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } branch_t;

  typedef struct packed {
    logic [2:0][31:0]  pos;
    logic [8:0][31:0]  mag;
    logic [8:0]        neg;
    logic [8:0][63:0]  sq;
    logic [2:0][63:0]  sx;
    logic [2:0][33:0]  srem;
    logic [2:0][31:0]  sroot;
    logic [2:0][31:0]  len;
    logic              degen;
    logic [8:0][31:0]  nrem;
    logic [8:0][16:0]  nq;
    logic [8:0][17:0]  m;
    branch_t           br;
    logic [35:0]       tx;
    logic [19:0]       trem;
    logic [17:0]       troot;
    logic [2:0][18:0]  d;
    logic [16:0]       main_c;
    logic [2:0]        dneg;
    logic [2:0]        ovf;
    logic [2:0][17:0]  qrem;
    logic [2:0][16:0]  qsh;
    logic [2:0][16:0]  qq;
    logic [2:0][30:0]  scale;
    logic [3:0][17:0]  quat;
  } item_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } lroot_t;

  typedef struct packed {
    logic [19:0] rem;
    logic [17:0] root;
  } troot_t;

  // One digit of the restoring square root of a 64-bit radicand.
  function automatic lroot_t len_root_step(lroot_t a, logic [1:0] pair);
    logic [35:0] cur;
    logic [35:0] trial;
    lroot_t      r;
    cur   = {a.rem, pair};
    trial = {2'b00, a.root, 2'b01};
    if (cur >= trial) begin
      cur    = cur - trial;
      r.root = {a.root[30:0], 1'b1};
    end else begin
      r.root = {a.root[30:0], 1'b0};
    end
    r.rem = cur[33:0];
    return r;
  endfunction

  // One digit of the restoring square root of a 36-bit radicand.
  function automatic troot_t t_root_step(troot_t a, logic [1:0] pair);
    logic [21:0] cur;
    logic [21:0] trial;
    troot_t      r;
    cur   = {a.rem, pair};
    trial = {2'b00, a.root, 2'b01};
    if (cur >= trial) begin
      cur    = cur - trial;
      r.root = {a.root[16:0], 1'b1};
    end else begin
      r.root = {a.root[16:0], 1'b0};
    end
    r.rem = cur[19:0];
    return r;
  endfunction

endpackage

>>> rtl/affine_matrix_decompose.sv
// ----------------------------------------------------------------------------
// affine_matrix_decompose: affine matrix to translation, scale and rotation
// Column lengths by digit-serial square roots, normalization and quaternion
// side components by restoring division, one digit per pipeline stage.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                     Content
// s_*      in   s_tvalid s_tready s_tdata   twelve matrix entries, 32 bits each
// m_*      out  m_tvalid m_tready m_tdata   position, scale, quaternion
//                              m_tuser      degenerate flag
//
// One matrix enters per cycle while no result waits at the output. The depth
// of the pipeline is set by the digit steps of the two square roots and the
// two divisions, each of which owns one stage per result bit.
// Reset clears only the stage valid bits. When a result waits at the output,
// the whole pipeline holds; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module affine_matrix_decompose
  import amd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z,
  // zaxis_x, zaxis_y, zaxis_z, trans_x, trans_y, trans_z
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
  // quat_x, quat_y, quat_z, quat_w, three zero pad bits
  output logic [263:0] m_tdata,
  // degenerate
  output logic         m_tuser
);

  item_t              pipe [NSTAGE];
  item_t              pipe_next [NSTAGE];
  logic [NSTAGE-1:0]  vld;
  logic               en;

  function automatic item_t stage_fn(int s, item_t a);
    item_t               r;
    lroot_t              lr;
    troot_t              tr;
    logic [32:0]         r2;
    logic [18:0]         cur;
    logic signed [19:0]  e [9];
    logic signed [19:0]  trace;
    logic signed [19:0]  t;
    logic [17:0]         dm;
    logic [33:0]         n;
    logic [18:0]         rp1;
    logic [16:0]         v;
    r = a;
    if (s == ST_SQ) begin
      for (int i = 0; i < 9; i++) r.sq[i] = 64'(a.mag[i]) * 64'(a.mag[i]);
    end else if (s == ST_SUM) begin
      for (int c = 0; c < 3; c++) begin
        r.sx[c]    = a.sq[3*c] + a.sq[3*c+1] + a.sq[3*c+2];
        r.srem[c]  = '0;
        r.sroot[c] = '0;
      end
    end else if (s >= ST_LEN0 && s < ST_NINIT) begin
      for (int c = 0; c < 3; c++) begin
        lr         = len_root_step({a.srem[c], a.sroot[c]}, a.sx[c][63:62]);
        r.srem[c]  = lr.rem;
        r.sroot[c] = lr.root;
        r.sx[c]    = {a.sx[c][61:0], 2'b00};
      end
    end else if (s == ST_NINIT) begin
      r.degen = 1'b0;
      for (int c = 0; c < 3; c++) begin
        r.len[c] = a.sroot[c];
        if (a.sroot[c] == '0) r.degen = 1'b1;
        r.scale[c] = a.sroot[c][31] ? 31'h7fffffff : a.sroot[c][30:0];
        for (int k = 0; k < 3; k++) begin
          if (a.mag[3*c+k] >= a.sroot[c]) begin
            r.nrem[3*c+k] = a.mag[3*c+k] - a.sroot[c];
            r.nq[3*c+k]   = 17'd1;
          end else begin
            r.nrem[3*c+k] = a.mag[3*c+k];
            r.nq[3*c+k]   = 17'd0;
          end
        end
      end
    end else if (s >= ST_NDIV0 && s < ST_SIGN) begin
      for (int i = 0; i < 9; i++) begin
        r2 = {a.nrem[i], 1'b0};
        if (r2 >= {1'b0, a.len[i/3]}) begin
          r2        = r2 - {1'b0, a.len[i/3]};
          r.nq[i]   = {a.nq[i][15:0], 1'b1};
        end else begin
          r.nq[i]   = {a.nq[i][15:0], 1'b0};
        end
        r.nrem[i] = r2[31:0];
      end
    end else if (s == ST_SIGN) begin
      for (int i = 0; i < 9; i++)
        r.m[i] = a.neg[i] ? (18'd0 - {1'b0, a.nq[i]}) : {1'b0, a.nq[i]};
    end else if (s == ST_BR) begin
      for (int i = 0; i < 9; i++) e[i] = 20'($signed(a.m[i]));
      trace = e[0] + e[4] + e[8];
      if (trace > 20'sd0) begin
        r.br = BR_W;
        t    = trace;
        r.d[0] = 19'(e[1] - e[3]);
        r.d[1] = 19'(e[6] - e[2]);
        r.d[2] = 19'(e[5] - e[7]);
      end else if (e[0] > e[4] && e[0] > e[8]) begin
        r.br = BR_X;
        t    = e[0] - e[4] - e[8];
        r.d[0] = 19'(e[1] + e[3]);
        r.d[1] = 19'(e[6] + e[2]);
        r.d[2] = 19'(e[5] - e[7]);
      end else if (e[4] > e[8]) begin
        r.br = BR_Y;
        t    = e[4] - e[0] - e[8];
        r.d[0] = 19'(e[1] + e[3]);
        r.d[1] = 19'(e[6] - e[2]);
        r.d[2] = 19'(e[5] + e[7]);
      end else begin
        r.br = BR_Z;
        t    = e[8] - e[0] - e[4];
        r.d[0] = 19'(e[1] - e[3]);
        r.d[1] = 19'(e[6] + e[2]);
        r.d[2] = 19'(e[5] + e[7]);
      end
      t = t + 20'($signed({1'b0, ONE_Q}));
      // A radicand at or below zero is clamped to one LSB.
      if (t < 20'sd1) t = 20'sd1;
      r.tx    = {1'b0, t[18:0], 16'h0000};
      r.trem  = '0;
      r.troot = '0;
    end else if (s >= ST_ROOT0 && s < ST_SINIT) begin
      tr      = t_root_step({a.trem, a.troot}, a.tx[35:34]);
      r.trem  = tr.rem;
      r.troot = tr.root;
      r.tx    = {a.tx[33:0], 2'b00};
    end else if (s == ST_SINIT) begin
      rp1      = {1'b0, a.troot} + 19'd1;
      r.main_c = rp1[17:1];
      for (int j = 0; j < 3; j++) begin
        r.dneg[j] = a.d[j][18];
        dm        = a.d[j][18] ? (18'd0 - a.d[j][17:0]) : a.d[j][17:0];
        n         = {1'b0, dm, 15'h0000} + {17'h0, a.troot[17:1]};
        // A quotient of 2^17 or more is far past one and saturates.
        r.ovf[j]  = {1'b0, n[33:17]} >= a.troot;
        r.qrem[j] = {1'b0, n[33:17]};
        r.qsh[j]  = n[16:0];
        r.qq[j]   = '0;
      end
    end else if (s >= ST_SDIV0 && s < ST_OUT) begin
      for (int j = 0; j < 3; j++) begin
        cur = {a.qrem[j], a.qsh[j][16]};
        if (cur >= {1'b0, a.troot}) begin
          cur     = cur - {1'b0, a.troot};
          r.qq[j] = {a.qq[j][15:0], 1'b1};
        end else begin
          r.qq[j] = {a.qq[j][15:0], 1'b0};
        end
        r.qrem[j] = cur[17:0];
        r.qsh[j]  = {a.qsh[j][15:0], 1'b0};
      end
    end else if (s == ST_OUT) begin
      for (int j = 0; j < 3; j++) begin
        v = (a.ovf[j] || a.qq[j] > ONE_Q) ? ONE_Q : a.qq[j];
        r.d[j] = {1'b0, a.dneg[j] ? (18'd0 - {1'b0, v}) : {1'b0, v}};
      end
      case (a.br)
        BR_W: r.quat = {{1'b0, a.main_c}, r.d[0][17:0], r.d[1][17:0], r.d[2][17:0]};
        BR_X: r.quat = {r.d[2][17:0], r.d[1][17:0], r.d[0][17:0], {1'b0, a.main_c}};
        BR_Y: r.quat = {r.d[1][17:0], r.d[2][17:0], {1'b0, a.main_c}, r.d[0][17:0]};
        BR_Z: r.quat = {r.d[0][17:0], {1'b0, a.main_c}, r.d[2][17:0], r.d[1][17:0]};
        default: r.quat = '0;
      endcase
      // quat is packed w, z, y, x from the top down.
      if (a.degen) r.quat = {QUAT_ONE, 18'h0, 18'h0, 18'h0};
    end
    return r;
  endfunction

  assign en       = !vld[NSTAGE-1] || m_tready;
  assign s_tready = en;

  always_comb begin
    pipe_next[0] = pipe[0];
    for (int i = 0; i < 9; i++) begin
      pipe_next[0].neg[i] = s_tdata[32*i+31];
      pipe_next[0].mag[i] = s_tdata[32*i+31] ? (32'd0 - s_tdata[32*i +: 32])
                                             : s_tdata[32*i +: 32];
    end
    for (int k = 0; k < 3; k++) pipe_next[0].pos[k] = s_tdata[288+32*k +: 32];
    for (int s = 1; s < NSTAGE; s++) pipe_next[s] = stage_fn(s, pipe[s-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NSTAGE; s++) pipe[s] <= pipe_next[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], s_tvalid};
    end
  end

  assign m_tvalid = vld[NSTAGE-1];
  assign m_tuser  = pipe[NSTAGE-1].degen;
  assign m_tdata  = {3'b000, pipe[NSTAGE-1].quat[3], pipe[NSTAGE-1].quat[2],
                     pipe[NSTAGE-1].quat[1], pipe[NSTAGE-1].quat[0],
                     pipe[NSTAGE-1].scale[2], pipe[NSTAGE-1].scale[1],
                     pipe[NSTAGE-1].scale[0], pipe[NSTAGE-1].pos[2],
                     pipe[NSTAGE-1].pos[1], pipe[NSTAGE-1].pos[0]};

  a_degen_unit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[260:243] == QUAT_ONE && m_tdata[242:189] == '0)
    else $error("degenerate result without unit quaternion");

  a_w_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[260:243]) <= $signed(QUAT_ONE)) &&
                 ($signed(m_tdata[260:243]) >= -$signed(QUAT_ONE)))
    else $error("quaternion w outside plus or minus one");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
    else $error("waiting result lost its flag");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for affine_matrix_decompose
// Drives directed matrices (identity, zero, extremes, each quaternion branch,
// degenerate columns) and then random ones, with random idle bursts on both
// stream sides. Every output transfer is compared with a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb;
  import amd_pkg::*;

  localparam int N_RANDOM = 1800;
  localparam int N_QUIET  = 200;
  localparam int LIMIT    = 300000;
  localparam logic [31:0] P1 = 32'h0001_0000;
  localparam logic [31:0] N1 = 32'hFFFF_0000;
  localparam logic [31:0] HI = 32'h7FFF_FFFF;
  localparam logic [31:0] LO = 32'h8000_0000;
  localparam logic [31:0] ZR = 32'h0000_0000;
  localparam int N_DIR = 15;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][30:0] scale;
    logic [3:0][17:0] quat;
    logic             degen;
  } decomp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [383:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b1;
  logic [263:0] m_tdata;
  logic         m_tuser;

  decomp_t pending_q[$];
  bit      quiet = 1'b0;
  bit      failed = 1'b0;
  int      cycles = 0;
  int      stall_left = 0;

  // Each row lists the words from the top down: trans_z, trans_y, trans_x,
  // then the z, y and x axes, each from row 2 down to row 0.
  logic [11:0][31:0] dir_tab [N_DIR] = '{
    {HI, LO, ZR, P1, ZR, ZR, ZR, P1, ZR, ZR, ZR, P1},
    {32'h1234_5678, 32'hFEDC_BA98, 32'h1, ZR, ZR, ZR, ZR, ZR, ZR, ZR, ZR, ZR},
    {LO, LO, LO, LO, LO, LO, LO, LO, LO, LO, LO, LO},
    {HI, HI, HI, HI, HI, HI, HI, HI, HI, HI, HI, HI},
    {ZR, ZR, ZR, N1, ZR, ZR, ZR, N1, ZR, ZR, ZR, P1},
    {ZR, ZR, ZR, N1, ZR, ZR, ZR, P1, ZR, ZR, ZR, N1},
    {ZR, ZR, ZR, P1, ZR, ZR, ZR, N1, ZR, ZR, ZR, N1},
    {ZR, ZR, ZR, P1, ZR, ZR, ZR, N1, ZR, P1, ZR, ZR},
    {ZR, ZR, ZR, ZR, P1, ZR, ZR, ZR, P1, P1, ZR, ZR},
    {ZR, ZR, ZR, P1, ZR, ZR, ZR, P1, ZR, ZR, ZR, ZR},
    {ZR, ZR, ZR, 32'h4000_0000, ZR, ZR, ZR, 32'h4000_0000, ZR, ZR, ZR, 32'h4000_0000},
    {ZR, ZR, ZR, 32'h1, ZR, ZR, ZR, 32'h1, ZR, ZR, ZR, 32'h1},
    {ZR, ZR, ZR, N1, ZR, ZR, ZR, P1, ZR, ZR, ZR, P1},
    {ZR, ZR, ZR, N1, ZR, ZR, ZR, N1, ZR, ZR, ZR, N1},
    {ZR, ZR, ZR, P1, ZR, ZR, ZR, P1, P1, ZR, ZR, P1}
  };

  affine_matrix_decompose uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0]  res;
    logic [127:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = {64'b0, res | (64'b1 << b)};
      if (cand * cand <= x) res = cand[63:0];
    end
    return res;
  endfunction

  function automatic longint norm_entry(logic [63:0] mag, bit neg, logic [63:0] len);
    logic [63:0] r;
    logic [63:0] q;
    r = mag;
    q = 0;
    if (r >= len) begin
      q = 1;
      r = r - len;
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      q = q << 1;
      if (r >= len - r) begin
        r = r - (len - r);
        q = q | 64'd1;
      end else begin
        r = r + r;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Off-diagonal component: d * 0.5 / sqrt(t), rounded, clamped to one.
  function automatic longint side_comp(longint d, logic [63:0] r);
    logic [63:0] mag;
    logic [63:0] v;
    mag = (d < 0) ? -d : d;
    v = ((mag << (FRAC_BITS - 1)) + (r >> 1)) / r;
    if (v > 64'h10000) v = 64'h10000;
    return (d < 0) ? -longint'(v) : longint'(v);
  endfunction

  function automatic logic [63:0] root_fix(longint t);
    if (t < 1) t = 1;
    return isqrt({64'b0, 64'(t) << FRAC_BITS});
  endfunction

  function automatic decomp_t decompose(logic [11:0][31:0] v);
    decomp_t     e;
    logic [63:0] mag [9];
    bit          neg [9];
    logic [63:0] len [3];
    logic [127:0] sum;
    longint      m [9];
    longint      q [4];
    logic [63:0] r;
    longint      one;
    one = 64'h10000;
    e.degen = 1'b0;
    for (int c = 0; c < 3; c++) begin
      sum = '0;
      for (int k = 0; k < 3; k++) begin
        neg[c*3+k] = v[c*3+k][31];
        mag[c*3+k] = neg[c*3+k] ? {32'b0, -v[c*3+k]} : {32'b0, v[c*3+k]};
        if (neg[c*3+k] && mag[c*3+k] == 0) mag[c*3+k] = 64'h8000_0000;
        sum = sum + {64'b0, mag[c*3+k]} * {64'b0, mag[c*3+k]};
      end
      len[c] = isqrt(sum);
      if (len[c] == 0) e.degen = 1'b1;
      e.scale[c] = (len[c] > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : len[c][30:0];
      e.pos[c] = v[9+c];
    end
    if (e.degen) begin
      q = '{0, 0, 0, one};
    end else begin
      for (int i = 0; i < 9; i++) m[i] = norm_entry(mag[i], neg[i], len[i/3]);
      if (m[0] + m[4] + m[8] > 0) begin
        r = root_fix(m[0] + m[4] + m[8] + one);
        q[3] = longint'((r + 1) >> 1);
        q[2] = side_comp(m[1] - m[3], r);
        q[1] = side_comp(m[6] - m[2], r);
        q[0] = side_comp(m[5] - m[7], r);
      end else if (m[0] > m[4] && m[0] > m[8]) begin
        r = root_fix(m[0] - m[4] - m[8] + one);
        q[0] = longint'((r + 1) >> 1);
        q[1] = side_comp(m[1] + m[3], r);
        q[2] = side_comp(m[6] + m[2], r);
        q[3] = side_comp(m[5] - m[7], r);
      end else if (m[4] > m[8]) begin
        r = root_fix(-m[0] + m[4] - m[8] + one);
        q[1] = longint'((r + 1) >> 1);
        q[0] = side_comp(m[1] + m[3], r);
        q[3] = side_comp(m[6] - m[2], r);
        q[2] = side_comp(m[5] + m[7], r);
      end else begin
        r = root_fix(-m[0] - m[4] + m[8] + one);
        q[2] = longint'((r + 1) >> 1);
        q[3] = side_comp(m[1] - m[3], r);
        q[0] = side_comp(m[6] + m[2], r);
        q[1] = side_comp(m[5] + m[7], r);
      end
    end
    for (int k = 0; k < 4; k++) e.quat[k] = q[k][17:0];
    return e;
  endfunction

  task automatic send_matrix(logic [11:0][31:0] v, decomp_t e);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_q.insert(pending_q.size(), e);
  endtask

  // Well-formed matrices are signed axis permutations with a common scale
  // and some noise; they reach all four quaternion branches.
  function automatic logic [11:0][31:0] random_matrix();
    logic [11:0][31:0] v;
    int          perm [3];
    int          mode;
    int          tmp;
    int          j;
    logic [31:0] s;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) v[i] = $urandom;
    if (mode >= 2 && mode <= 5) begin
      perm = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      s = $urandom_range(1, 32'h0010_0000);
      for (int c = 0; c < 3; c++)
        for (int k = 0; k < 3; k++) begin
          v[c*3+k] = 32'($urandom_range(0, s / 4 + 1)) - 32'(s / 8);
          if (perm[c] == k) v[c*3+k] = $urandom_range(0, 1) ? s : -s;
        end
    end else if (mode >= 6 && mode <= 8) begin
      for (int i = 0; i < 9; i++) v[i] = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    end else if (mode == 9) begin
      tmp = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) v[tmp*3+k] = '0;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
    end else if (!m_tready && stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!m_tready) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    decomp_t e;
    decomp_t a;
    if (!rst && m_tvalid && m_tready) begin
      for (int i = 0; i < 3; i++) begin
        a.pos[i] = m_tdata[32*i +: 32];
        a.scale[i] = m_tdata[96 + 31*i +: 31];
      end
      for (int i = 0; i < 4; i++) a.quat[i] = m_tdata[189 + 18*i +: 18];
      a.degen = m_tuser;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %h", $time, a);
        failed = 1'b1;
      end else begin
        e = pending_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (a.pos[i] !== e.pos[i]) begin
            $display("%0t: pos[%0d] expected %h actual %h", $time, i, e.pos[i], a.pos[i]);
            failed = 1'b1;
          end
          if (a.scale[i] !== e.scale[i]) begin
            $display("%0t: scale[%0d] expected %h actual %h", $time, i, e.scale[i], a.scale[i]);
            failed = 1'b1;
          end
        end
        for (int i = 0; i < 4; i++)
          if (a.quat[i] !== e.quat[i]) begin
            $display("%0t: quat[%0d] expected %h actual %h", $time, i, e.quat[i], a.quat[i]);
            failed = 1'b1;
          end
        if (a.degen !== e.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, e.degen, a.degen);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    decomp_t e;
    logic [11:0][31:0] v;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIR; i++) begin
      // Identity and the zero matrix have results known by inspection.
      if (i == 0) begin
        e.pos = {HI, LO, 32'h0};
        e.scale = {3{31'h1_0000}};
        e.quat = {QUAT_ONE, 18'h0, 18'h0, 18'h0};
        e.degen = 1'b0;
      end else if (i == 1) begin
        e.pos = {32'h1234_5678, 32'hFEDC_BA98, 32'h1};
        e.scale = '0;
        e.quat = {QUAT_ONE, 18'h0, 18'h0, 18'h0};
        e.degen = 1'b1;
      end else begin
        e = decompose(dir_tab[i]);
      end
      send_matrix(dir_tab[i], e);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_QUIET) quiet = 1'b1;
      v = random_matrix();
      send_matrix(v, decompose(v));
    end
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
